>>> design/ffo_pkg.sv
// ----------------------------------------------------------------------------
// ffo_pkg
// Shared types and constants for the first-fit offcut packer.
// ----------------------------------------------------------------------------
package ffo_pkg;

   localparam int MAX_OFFCUTS_DEF = 64;
   localparam int LENGTH_BITS_DEF = 16;

   localparam int FIELD_BITS = 16;
   localparam logic [FIELD_BITS-1:0] STOCK_RESET = 16'd2400;
   localparam logic [FIELD_BITS-1:0] TALLY_MAX   = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } ffo_state_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] boards_bought;
      logic                  new_board;
      logic                  list_overflow;
      logic                  job_done;
   } ffo_result_type;

endpackage

>>> design/first_fit_offcut_packer_unit.sv
// ----------------------------------------------------------------------------
// first_fit_offcut_packer_unit
// First-fit cutting-stock packer with a stock-length register and a
// registered result word.
// ----------------------------------------------------------------------------
// Sequence: scan the offcuts held for the first that fits; cut from it, or on an
//   exact fit remove it and shift the rest down, or with no fit open a new board.
// Flow: one piece at a time; a new piece is taken only after the result word is
//   passed to the result register, so result stalls hold off new pieces too.
// Reset: synchronous; clears offcut count and board tally, stock length returns
//   to 2400. The offcut store itself is not cleared.
module first_fit_offcut_packer_unit #(
   parameter int MAX_OFFCUTS = ffo_pkg::MAX_OFFCUTS_DEF,
   parameter int LENGTH_BITS = ffo_pkg::LENGTH_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ffo_pkg::FIELD_BITS-1:0] csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ffo_pkg::FIELD_BITS-1:0] req_piece_length,
   input  logic                           req_last_piece,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ffo_pkg::FIELD_BITS-1:0] rsp_boards_bought,
   output logic                           rsp_new_board,
   output logic                           rsp_list_overflow,
   output logic                           rsp_job_done
);

   logic [ffo_pkg::FIELD_BITS-1:0] stock_ff;
   logic                           rsp_valid_ff;
   ffo_pkg::ffo_result_type        rsp_ff;
   ffo_pkg::ffo_result_type        res;
   logic                           res_valid;
   logic                           res_ready;

   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         stock_ff <= ffo_pkg::STOCK_RESET;
      end else if (csr_wr_en) begin
         stock_ff <= csr_wr_data;
      end
   end

   ffo_engine #(
      .MAX_OFFCUTS (MAX_OFFCUTS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_piece  (req_piece_length),
      .in_last   (req_last_piece),
      .stock     (stock_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) rsp_ff <= res;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_boards_bought = rsp_ff.boards_bought;
   assign rsp_new_board     = rsp_ff.new_board;
   assign rsp_list_overflow = rsp_ff.list_overflow;
   assign rsp_job_done      = rsp_ff.job_done;

endmodule

>>> design/ffo_engine.sv
// ----------------------------------------------------------------------------
// ffo_engine
// Offcut store with scan, cut, remove-and-shift and append sequencing.
// ----------------------------------------------------------------------------
module ffo_engine #(
   parameter int MAX_OFFCUTS = ffo_pkg::MAX_OFFCUTS_DEF,
   parameter int LENGTH_BITS = ffo_pkg::LENGTH_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_stall,
   input  logic [ffo_pkg::FIELD_BITS-1:0]   in_piece,
   input  logic                             in_last,
   input  logic [ffo_pkg::FIELD_BITS-1:0]   stock,
   output logic                             res_valid,
   input  logic                             res_ready,
   output ffo_pkg::ffo_result_type          res
);

   localparam int AW = (MAX_OFFCUTS > 1) ? $clog2(MAX_OFFCUTS) : 1;
   localparam int CW = $clog2(MAX_OFFCUTS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_OFFCUTS);

   ffo_pkg::ffo_state_type state_ff, state_in;

   logic [LENGTH_BITS-1:0] offcut_mem_ff [MAX_OFFCUTS];
   logic [LENGTH_BITS-1:0] rd_q_ff;

   logic [CW-1:0]                 count_ff;
   logic [ffo_pkg::FIELD_BITS-1:0] tally_ff;
   logic [LENGTH_BITS-1:0]        piece_ff;
   logic                          last_ff;
   logic [CW-1:0]                 scan_ff;
   logic                          chk_vld_ff;
   logic [AW-1:0]                 chk_idx_ff;
   logic                          fresh_ff;
   logic                          ovf_ff;

   logic [31:0]            piece_wide;
   logic [31:0]            stock_wide;
   logic [LENGTH_BITS-1:0] piece_len;
   logic [LENGTH_BITS-1:0] stock_len;

   logic accept;
   logic fit_gt;
   logic fit_eq;
   logic issue;
   logic scan_end;
   logic shift_end;
   logic do_append;
   logic do_drop;

   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [LENGTH_BITS-1:0] wr_data;

   assign piece_wide = 32'(in_piece);
   assign stock_wide = 32'(stock);
   assign piece_len  = piece_wide[LENGTH_BITS-1:0];
   assign stock_len  = stock_wide[LENGTH_BITS-1:0];

   assign accept    = (state_ff == ffo_pkg::ST_IDLE) && in_valid;
   assign fit_gt    = chk_vld_ff && (rd_q_ff > piece_ff);
   assign fit_eq    = chk_vld_ff && (rd_q_ff == piece_ff);
   assign issue     = scan_ff < count_ff;
   assign scan_end  = !fit_gt && !fit_eq && !issue;
   assign shift_end = !issue;
   assign do_append = scan_end && (stock_len > piece_ff) && (count_ff < CNT_MAX);
   assign do_drop   = scan_end && (stock_len > piece_ff) && (count_ff >= CNT_MAX);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffo_pkg::ST_IDLE: begin
            if (in_valid) state_in = ffo_pkg::ST_SCAN;
         end
         ffo_pkg::ST_SCAN: begin
            if (fit_eq) state_in = ffo_pkg::ST_SHIFT;
            else if (fit_gt || scan_end) state_in = ffo_pkg::ST_FINISH;
         end
         ffo_pkg::ST_SHIFT: begin
            if (shift_end) state_in = ffo_pkg::ST_FINISH;
         end
         ffo_pkg::ST_FINISH: begin
            if (res_ready) state_in = ffo_pkg::ST_IDLE;
         end
         default: state_in = ffo_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      in_stall  = 1'b1;
      res_valid = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = scan_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = chk_idx_ff;
      wr_data   = rd_q_ff;
      case (state_ff)
         ffo_pkg::ST_IDLE: begin
            in_stall = 1'b0;
         end
         ffo_pkg::ST_SCAN: begin
            rd_en = issue;
            if (fit_gt) begin
               wr_en   = 1'b1;
               wr_data = rd_q_ff - piece_ff;
            end else if (do_append) begin
               wr_en   = 1'b1;
               wr_addr = count_ff[AW-1:0];
               wr_data = stock_len - piece_ff;
            end
         end
         ffo_pkg::ST_SHIFT: begin
            rd_en   = issue;
            wr_en   = chk_vld_ff;
            wr_addr = chk_idx_ff - AW'(1);
         end
         ffo_pkg::ST_FINISH: begin
            res_valid = 1'b1;
         end
         default: begin
            in_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_q_ff <= offcut_mem_ff[rd_addr];
      if (wr_en) offcut_mem_ff[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ffo_pkg::ST_IDLE;
         count_ff   <= '0;
         tally_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ffo_pkg::ST_IDLE: begin
               chk_vld_ff <= 1'b0;
            end
            ffo_pkg::ST_SCAN: begin
               if (fit_eq) begin
                  chk_vld_ff <= 1'b0;
               end else begin
                  chk_vld_ff <= issue;
               end
               if (scan_end) begin
                  if (tally_ff != ffo_pkg::TALLY_MAX) tally_ff <= tally_ff + 1'b1;
                  if (do_append) count_ff <= count_ff + 1'b1;
               end
            end
            ffo_pkg::ST_SHIFT: begin
               chk_vld_ff <= issue;
               if (shift_end) count_ff <= count_ff - 1'b1;
            end
            ffo_pkg::ST_FINISH: begin
               if (res_ready && last_ff) begin
                  count_ff <= '0;
                  tally_ff <= '0;
               end
            end
            default: begin
               chk_vld_ff <= 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         piece_ff <= piece_len;
         last_ff  <= in_last;
         scan_ff  <= '0;
         fresh_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (state_ff == ffo_pkg::ST_SCAN) begin
         if (fit_eq) begin
            scan_ff <= CW'(chk_idx_ff) + 1'b1;
         end else if (issue) begin
            scan_ff    <= scan_ff + 1'b1;
            chk_idx_ff <= scan_ff[AW-1:0];
         end
         if (scan_end) begin
            fresh_ff <= 1'b1;
            ovf_ff   <= do_drop;
         end
      end else if (state_ff == ffo_pkg::ST_SHIFT) begin
         if (issue) begin
            scan_ff    <= scan_ff + 1'b1;
            chk_idx_ff <= scan_ff[AW-1:0];
         end
      end
   end

   assign res.boards_bought = tally_ff;
   assign res.new_board     = fresh_ff;
   assign res.list_overflow = ovf_ff;
   assign res.job_done      = last_ff;

endmodule

>>> tb/sv/offcut_pack_checker.sv
// ----------------------------------------------------------------------------
// offcut_pack_checker
// Watches the piece, result and register ports of the offcut packer, keeps
// its own offcut list, board tally and stock length, predicts one result
// word per accepted piece and compares every accepted result word with the
// oldest prediction. Hands the failure count and the number of predictions
// still due to the testbench top.
// ----------------------------------------------------------------------------
module offcut_pack_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ffo_pkg::FIELD_BITS-1:0] csr_wr_data,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [ffo_pkg::FIELD_BITS-1:0] req_piece_length,
   input  logic                           req_last_piece,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [ffo_pkg::FIELD_BITS-1:0] rsp_boards_bought,
   input  logic                           rsp_new_board,
   input  logic                           rsp_list_overflow,
   input  logic                           rsp_job_done,
   output int                             error_count,
   output int                             words_in_flight
);

   localparam int LIST_DEPTH = ffo_pkg::MAX_OFFCUTS_DEF;
   localparam int WORD_BITS  = ffo_pkg::FIELD_BITS;

   logic [WORD_BITS-1:0]    offcuts [LIST_DEPTH];
   int                      offcut_total = 0;
   logic [WORD_BITS-1:0]    tally = '0;
   logic [WORD_BITS-1:0]    stock = ffo_pkg::STOCK_RESET;
   ffo_pkg::ffo_result_type due_words [$];
   int                      errs = 0;

   function automatic ffo_pkg::ffo_result_type cut_piece(
      input logic [WORD_BITS-1:0] piece,
      input logic                 last);
      ffo_pkg::ffo_result_type word;
      logic                    placed;
      word   = '0;
      placed = 1'b0;
      for (int i = 0; i < offcut_total && !placed; i++) begin
         if (offcuts[i] > piece) begin
            offcuts[i] = offcuts[i] - piece;
            placed     = 1'b1;
         end else if (offcuts[i] == piece) begin
            for (int j = i; j + 1 < offcut_total; j++) offcuts[j] = offcuts[j + 1];
            offcut_total--;
            placed = 1'b1;
         end
      end
      if (!placed) begin
         word.new_board = 1'b1;
         if (tally != ffo_pkg::TALLY_MAX) tally++;
         if (stock > piece) begin
            if (offcut_total < LIST_DEPTH) begin
               offcuts[offcut_total] = stock - piece;
               offcut_total++;
            end else begin
               word.list_overflow = 1'b1;
            end
         end
      end
      word.boards_bought = tally;
      word.job_done      = last;
      if (last) begin
         offcut_total = 0;
         tally        = '0;
      end
      return word;
   endfunction

   function automatic void check_field(input string name,
                                       input logic [WORD_BITS-1:0] want,
                                       input logic [WORD_BITS-1:0] got);
      if (got !== want) begin
         errs++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      ffo_pkg::ffo_result_type want;
      if (reset) begin
         offcut_total = 0;
         tally        = '0;
         stock        = ffo_pkg::STOCK_RESET;
         due_words.delete();
      end else begin
         if (csr_wr_en) stock = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               errs++;
               $error("result word with no prediction: boards_bought %0d",
                      rsp_boards_bought);
            end else begin
               want = due_words.pop_front();
               check_field("boards_bought", want.boards_bought, rsp_boards_bought);
               check_field("new_board", WORD_BITS'(want.new_board),
                           WORD_BITS'(rsp_new_board));
               check_field("list_overflow", WORD_BITS'(want.list_overflow),
                           WORD_BITS'(rsp_list_overflow));
               check_field("job_done", WORD_BITS'(want.job_done),
                           WORD_BITS'(rsp_job_done));
            end
         end
         if (req_valid && !req_stall)
            due_words.push_back(cut_piece(req_piece_length, req_last_piece));
      end
      error_count     <= errs;
      words_in_flight <= due_words.size();
   end

endmodule

>>> tb/sv/tb_first_fit_offcut_packer_unit.sv
// ----------------------------------------------------------------------------
// tb_first_fit_offcut_packer_unit
// Drives pieces and stock-length writes into the first-fit offcut packer:
// a directed run over the edge cases, a full-list run and random jobs under
// several stock lengths, with bursty input, a patterned result stall and one
// long result hold-off. The checker beside the block predicts and compares;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_first_fit_offcut_packer_unit;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 2 * ffo_pkg::MAX_OFFCUTS_DEF + 8;
   localparam int WORD_BITS      = ffo_pkg::FIELD_BITS;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COIN} stall_mode_type;
   typedef enum int {JOB_FILL, JOB_SPREAD, JOB_EDGE, JOB_NOISE} job_style_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [WORD_BITS-1:0] csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [WORD_BITS-1:0] req_piece_length = '0;
   logic                 req_last_piece = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [WORD_BITS-1:0] rsp_boards_bought;
   logic                 rsp_new_board;
   logic                 rsp_list_overflow;
   logic                 rsp_job_done;

   int                   pack_errors;
   int                   pack_in_flight;

   int                   burst_left = 0;
   int                   holdoff_request = 0;
   logic [WORD_BITS-1:0] stock_now = ffo_pkg::STOCK_RESET;

   first_fit_offcut_packer_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_piece_length  (req_piece_length),
      .req_last_piece    (req_last_piece),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_boards_bought (rsp_boards_bought),
      .rsp_new_board     (rsp_new_board),
      .rsp_list_overflow (rsp_list_overflow),
      .rsp_job_done      (rsp_job_done)
   );

   offcut_pack_checker pack_check (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_piece_length  (req_piece_length),
      .req_last_piece    (req_last_piece),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_boards_bought (rsp_boards_bought),
      .rsp_new_board     (rsp_new_board),
      .rsp_list_overflow (rsp_list_overflow),
      .rsp_job_done      (rsp_job_done),
      .error_count       (pack_errors),
      .words_in_flight   (pack_in_flight)
   );

   always #5 clock = ~clock;

   // offer one word and hold it until accepted
   task automatic offer(input logic [WORD_BITS-1:0] len, input logic last);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid        <= 1'b1;
      req_piece_length <= len;
      req_last_piece   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pack_in_flight != 0) @(negedge clock);
   endtask

   task automatic set_stock(input logic [WORD_BITS-1:0] len);
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      stock_now    = len;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [WORD_BITS-1:0] pick_stock();
      case ($urandom_range(0, 5))
         0:       return 16'd1;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(2, 30));
         3:       return 16'($urandom_range(100, 3000));
         4:       return 16'($urandom_range(1, 65535));
         default: return ffo_pkg::STOCK_RESET;
      endcase
   endfunction

   // receiver stall pattern, with the long hold-off counted here
   initial begin
      int             run_left;
      int             holdoff_left;
      stall_mode_type mode;
      run_left     = 0;
      holdoff_left = 0;
      mode         = STALL_NONE;
      forever begin
         @(negedge clock);
         if (holdoff_request > 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
         end
         if (holdoff_left > 0) begin
            rsp_stall <= 1'b1;
            holdoff_left--;
         end else begin
            if (run_left == 0) begin
               mode     = stall_mode_type'($urandom_range(0, 3));
               run_left = $urandom_range(5, 60);
            end
            run_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
         if (idle >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int                   offered;
      int                   job_len;
      int                   phase;
      job_style_type        style;
      logic [WORD_BITS-1:0] len;
      logic                 last;
      offered = 0;
      phase   = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edge cases under the reset stock length
      offer(16'd0, 1'b0);
      offer(16'd0, 1'b0);
      offer(16'd2400, 1'b0);
      offer(16'd2400, 1'b0);
      offer(16'hFFFF, 1'b0);
      offer(16'd1000, 1'b0);
      offer(16'd600, 1'b0);
      offer(16'd900, 1'b0);
      offer(16'd800, 1'b0);
      offer(16'd1500, 1'b1);
      offer(16'h5555, 1'b0);
      offer(16'hAAAA, 1'b1);

      set_stock(16'd1);
      offer(16'd0, 1'b0);
      offer(16'd1, 1'b0);
      offer(16'd1, 1'b0);
      offer(16'd2, 1'b1);

      set_stock(16'hFFFF);
      offer(16'hFFFF, 1'b0);
      offer(16'd0, 1'b0);
      offer(16'hFFFE, 1'b0);
      offer(16'd1, 1'b1);

      // fill the list past its depth
      set_stock(16'd1000);
      for (int k = 0; k <= ffo_pkg::MAX_OFFCUTS_DEF + 2; k++)
         offer(16'(600 + k), k == ffo_pkg::MAX_OFFCUTS_DEF + 2);

      while (offered < RANDOM_ITEMS) begin
         set_stock(pick_stock());
         if (phase == 1) holdoff_request = HOLDOFF_CYCLES;
         style   = job_style_type'($urandom_range(0, 3));
         job_len = $urandom_range(1, 90);
         for (int k = 0; k < job_len; k++) begin
            last = (k == job_len - 1);
            case (style)
               JOB_FILL:   len = 16'((stock_now >> 1) + 1 + k);
               JOB_SPREAD: len = 16'($urandom_range(0, stock_now));
               JOB_EDGE: begin
                  case ($urandom_range(0, 3))
                     0:       len = '0;
                     1:       len = stock_now;
                     2:       len = 16'(stock_now + 1);
                     default: len = 16'($urandom_range(0, stock_now));
                  endcase
               end
               default: begin
                  len  = 16'($urandom());
                  last = ($urandom_range(0, 7) == 0);
               end
            endcase
            offer(len, last);
            offered++;
            if ($urandom_range(0, 40) == 0) quiesce();
         end
         phase++;
      end

      quiesce();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pack_errors == 0 && pack_in_flight == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
